// ===== rtl/gnw_pkg.sv =====
// Shared types, clip codes and digit helpers for the German number-to-words block.
package gnw_pkg;

  localparam int VALUE_W   = 20;
  localparam int CODE_W    = 5;
  localparam int MAX_WORDS = 13;
  localparam int CNT_W     = 4;
  localparam int GRP_WORDS = 7;
  localparam int GRP_CNT_W = 3;

  // floor(v / 1000) = (v * RECIP_1000) >> RECIP_SHIFT for any 20-bit v
  localparam int RECIP_SHIFT = 30;
  localparam logic [20:0] RECIP_1000 = 21'd1073742;

  localparam logic [CODE_W-1:0] W_NULL    = 5'd1;
  localparam logic [CODE_W-1:0] W_ONE     = 5'd2;
  localparam logic [CODE_W-1:0] W_EIN     = 5'd11;
  localparam logic [CODE_W-1:0] W_ELF     = 5'd12;
  localparam logic [CODE_W-1:0] W_HUNDERT = 5'd13;
  localparam logic [CODE_W-1:0] W_SECH    = 5'd14;
  localparam logic [CODE_W-1:0] W_SIEB    = 5'd15;
  localparam logic [CODE_W-1:0] W_TAUSEND = 5'd16;
  localparam logic [CODE_W-1:0] W_UND     = 5'd17;
  localparam logic [CODE_W-1:0] W_ZEHN    = 5'd18;
  localparam logic [CODE_W-1:0] W_ZIG     = 5'd19;
  localparam logic [CODE_W-1:0] W_ZWAN    = 5'd20;
  localparam logic [CODE_W-1:0] W_ZWOELF  = 5'd21;

  typedef struct packed {
    logic [3:0] d5;
    logic [3:0] d4;
    logic [3:0] d3;
    logic [3:0] d2;
    logic [3:0] d1;
    logic [3:0] d0;
  } digits_t;

  typedef struct packed {
    logic [GRP_WORDS-1:0][CODE_W-1:0] codes;
    logic [GRP_CNT_W-1:0]             cnt;
  } grp_t;

  typedef logic [MAX_WORDS-1:0][CODE_W-1:0] wlist_t;

  function automatic logic [CODE_W-1:0] digit_clip(logic [3:0] d);
    return CODE_W'(d) + 5'd1;
  endfunction

  function automatic logic [CODE_W-1:0] prefix_clip(logic [3:0] d);
    logic [CODE_W-1:0] c;
    case (d)
      4'd2:    c = W_ZWAN;
      4'd6:    c = W_SECH;
      4'd7:    c = W_SIEB;
      default: c = digit_clip(d);
    endcase
    return c;
  endfunction

  function automatic logic [CODE_W-1:0] ein_clip(logic [3:0] d);
    return (d == 4'd1) ? W_EIN : digit_clip(d);
  endfunction

  // x < 1000
  function automatic logic [3:0] div100(logic [9:0] x);
    logic [3:0] h;
    h = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (x >= 10'(k * 100)) h = h + 4'd1;
    end
    return h;
  endfunction

  // r < 100
  function automatic logic [3:0] div10(logic [6:0] r);
    logic [3:0] t;
    t = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (r >= 7'(k * 10)) t = t + 4'd1;
    end
    return t;
  endfunction

  // one three-digit group, optionally closed by tausend when nonzero
  function automatic grp_t put_group(logic [3:0] h, logic [3:0] t, logic [3:0] o,
                                     logic [CODE_W-1:0] lone_one, logic add_tausend);
    grp_t g;
    logic [GRP_CNT_W-1:0] n;
    g = '0;
    n = '0;
    if (h != 4'd0) begin
      g.codes[n] = ein_clip(h);
      n = n + 3'd1;
      g.codes[n] = W_HUNDERT;
      n = n + 3'd1;
    end
    if (t == 4'd1) begin
      if (o == 4'd0) begin
        g.codes[n] = W_ZEHN;
        n = n + 3'd1;
      end else if (o == 4'd1) begin
        g.codes[n] = W_ELF;
        n = n + 3'd1;
      end else if (o == 4'd2) begin
        g.codes[n] = W_ZWOELF;
        n = n + 3'd1;
      end else begin
        g.codes[n] = prefix_clip(o);
        n = n + 3'd1;
        g.codes[n] = W_ZEHN;
        n = n + 3'd1;
      end
    end else if (t > 4'd1) begin
      if (o != 4'd0) begin
        g.codes[n] = ein_clip(o);
        n = n + 3'd1;
        g.codes[n] = W_UND;
        n = n + 3'd1;
      end
      g.codes[n] = prefix_clip(t);
      n = n + 3'd1;
      g.codes[n] = W_ZIG;
      n = n + 3'd1;
    end else if (o != 4'd0) begin
      g.codes[n] = (o == 4'd1) ? lone_one : digit_clip(o);
      n = n + 3'd1;
    end
    if (add_tausend && (h != 4'd0 || t != 4'd0 || o != 4'd0)) begin
      g.codes[n] = W_TAUSEND;
      n = n + 3'd1;
    end
    g.cnt = n;
    return g;
  endfunction

endpackage

// ===== rtl/gnw_digits.sv =====
// Four-stage decimal digit splitter: 20-bit value to six decimal digits.
module gnw_digits
  import gnw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output digits_t            out_digits
);

  localparam int PROD1_W = VALUE_W + 21;

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  logic [VALUE_W-1:0] val1;
  logic [10:0]        quo1;
  logic [9:0]         lo2, hi2;
  logic [3:0]         hl3, hh3;
  logic [6:0]         rl3, rh3;
  digits_t            dig4;

  logic [PROD1_W-1:0] prod1;
  logic [20:0]        prod2, lo_full;
  logic [10:0]        hi_full;
  logic [3:0]         hl_c, hh_c, tl_c, th_c;

  assign en4 = !v4 || out_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1;

  assign prod1   = PROD1_W'(in_value) * PROD1_W'(RECIP_1000);
  assign prod2   = 21'(quo1) * 21'd1000;
  assign lo_full = 21'(val1) - prod2;
  assign hi_full = (quo1 >= 11'd1000) ? (quo1 - 11'd1000) : quo1;
  assign hl_c    = div100(lo2);
  assign hh_c    = div100(hi2);
  assign tl_c    = div10(rl3);
  assign th_c    = div10(rh3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      val1 <= in_value;
      quo1 <= prod1[RECIP_SHIFT +: 11];
    end
    if (en2) begin
      lo2 <= lo_full[9:0];
      hi2 <= hi_full[9:0];
    end
    if (en3) begin
      hl3 <= hl_c;
      hh3 <= hh_c;
      rl3 <= 7'(10'(lo2) - 10'(hl_c) * 10'd100);
      rh3 <= 7'(10'(hi2) - 10'(hh_c) * 10'd100);
    end
    if (en4) begin
      dig4.d5 <= hh3;
      dig4.d4 <= th_c;
      dig4.d3 <= 4'(rh3 - 7'(th_c) * 7'd10);
      dig4.d2 <= hl3;
      dig4.d1 <= tl_c;
      dig4.d0 <= 4'(rl3 - 7'(tl_c) * 7'd10);
    end
  end

  assign out_valid  = v4;
  assign out_digits = dig4;

`ifndef SYNTHESIS
  a_digits_decimal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_digits.d5 <= 4'd9 && out_digits.d4 <= 4'd9 && out_digits.d3 <= 4'd9 &&
                   out_digits.d2 <= 4'd9 && out_digits.d1 <= 4'd9 && out_digits.d0 <= 4'd9))
    else $error("digit out of decimal range");
`endif

endmodule

// ===== rtl/gnw_words.sv =====
// Two-stage word builder: six digits to a packed list of clip codes and a count.
module gnw_words
  import gnw_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  digits_t          in_digits,
  output logic             out_valid,
  input  logic             out_ready,
  output wlist_t           out_list,
  output logic [CNT_W-1:0] out_cnt
);

  logic v1, v2, en1, en2;
  grp_t   gt1, gu1;
  wlist_t list2, list_c;
  logic [CNT_W-1:0] cnt2, cnt_c;

  assign en2 = !v2 || out_ready;
  assign en1 = !v1 || en2;
  assign in_ready = en1;

  // thousands group first, units group packed right after it
  always_comb begin
    logic [CNT_W-1:0] j;
    list_c = '0;
    for (int i = 0; i < MAX_WORDS; i++) begin
      j = CNT_W'(i) - CNT_W'(gt1.cnt);
      if (CNT_W'(i) < CNT_W'(gt1.cnt)) begin
        list_c[i] = gt1.codes[i % GRP_WORDS];
      end else if (j < CNT_W'(GRP_WORDS)) begin
        list_c[i] = gu1.codes[j[GRP_CNT_W-1:0]];
      end
    end
    cnt_c = CNT_W'(gt1.cnt) + CNT_W'(gu1.cnt);
    if (cnt_c == '0) begin
      list_c[0] = W_NULL;
      cnt_c     = CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      gt1 <= put_group(in_digits.d5, in_digits.d4, in_digits.d3, W_EIN, 1'b1);
      gu1 <= put_group(in_digits.d2, in_digits.d1, in_digits.d0, W_ONE, 1'b0);
    end
    if (en2) begin
      list2 <= list_c;
      cnt2  <= cnt_c;
    end
  end

  assign out_valid = v2;
  assign out_list  = list2;
  assign out_cnt   = cnt2;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_cnt != '0 && out_cnt <= CNT_W'(MAX_WORDS)))
    else $error("word count out of range");
`endif

endmodule

// ===== rtl/gnw_serial.sv =====
// Output shifter: emits one clip code per cycle while out_ready is high, from a loaded word list.
module gnw_serial
  import gnw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  wlist_t            in_list,
  input  logic [CNT_W-1:0]  in_cnt,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CODE_W-1:0] out_code,
  output logic              out_last
);

  wlist_t           list;
  logic [CNT_W-1:0] rem;
  logic             pop, load;

  assign out_valid = (rem != '0);
  assign pop       = out_valid && out_ready;
  assign in_ready  = (rem == '0) || (rem == CNT_W'(1) && pop);
  assign load      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (load) begin
      rem <= in_cnt;
    end else if (pop) begin
      rem <= rem - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      list <= in_list;
    end else if (pop) begin
      list <= {{CODE_W{1'b0}}, list[MAX_WORDS-1:1]};
    end
  end

  assign out_code = list[0];
  assign out_last = (rem == CNT_W'(1));

`ifndef SYNTHESIS
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_code != 5'd0 && out_code <= W_ZWOELF))
    else $error("clip code out of range");
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (pop && !out_last) |=> out_valid)
    else $error("word run broken before last word");
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> (out_valid && rem == $past(in_cnt)))
    else $error("loaded list not presented");
`endif

endmodule

// ===== rtl/german_number_to_word_tokens.sv =====
// Top level: number to German word-clip code stream.
//
//  channel | dir | tdata fields (low bit up)   | tlast
//  s_      | in  | value[19:0], pad to 24 bits | -
//  m_      | out | word_code[4:0], pad to 8    | last_word
//
// Seven register stages: four for digit split, two for word list build, one output shifter.
// The first word is valid once an accepted item has passed the digit, word and shifter registers;
// a number yields 1 to 13 words, one per cycle while m_tready is high.
// The output shifter takes the next list in the cycle its last word leaves.
// rst (synchronous) clears all valid bits; a low m_tready holds the shifter's current word in place,
// while earlier stages still advance into empty stages and hold only behind a full one.
module german_number_to_word_tokens
  import gnw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [19:0] value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [4:0] word_code
  output logic        m_tlast
);

  logic             dig_valid, dig_ready;
  digits_t          dig;
  logic             wl_valid, wl_ready;
  wlist_t           wl_list;
  logic [CNT_W-1:0] wl_cnt;
  logic [CODE_W-1:0] code;

  gnw_digits u_digits (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_value   (s_tdata[VALUE_W-1:0]),
    .out_valid  (dig_valid),
    .out_ready  (dig_ready),
    .out_digits (dig)
  );

  gnw_words u_words (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dig_valid),
    .in_ready  (dig_ready),
    .in_digits (dig),
    .out_valid (wl_valid),
    .out_ready (wl_ready),
    .out_list  (wl_list),
    .out_cnt   (wl_cnt)
  );

  gnw_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (wl_valid),
    .in_ready  (wl_ready),
    .in_list   (wl_list),
    .in_cnt    (wl_cnt),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_code  (code),
    .out_last  (m_tlast)
  );

  assign m_tdata = {3'b000, code};

endmodule

// ===== test/german_number_to_word_tokens_tb.sv =====
// Testbench for german_number_to_word_tokens: directed and random numbers against a word predictor.
`timescale 1ns / 100ps

module german_number_to_word_tokens_tb
  import gnw_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
  } word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;  // [19:0] value
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;       // [4:0] word_code
  logic        m_tlast;

  word_t             expected_words[$];
  logic [CODE_W-1:0] phrase[$];
  int                send_gap_pct;
  int                sink_stall_pct;
  int                n_errors = 0;
  int                quiet_cycles = 0;

  german_number_to_word_tokens i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  always #1 clk = ~clk;

  // ---- word predictor ----
  function automatic logic [CODE_W-1:0] digit_word(int unsigned d);
    return CODE_W'(d + 1);
  endfunction

  // 1 before hundert, tausend or und is spoken "ein"
  function automatic logic [CODE_W-1:0] ein_word(int unsigned d);
    if (d == 1) return W_EIN;
    return digit_word(d);
  endfunction

  // stem before zehn or zig
  function automatic logic [CODE_W-1:0] tens_stem(int unsigned d);
    case (d)
      2:       return W_ZWAN;
      6:       return W_SECH;
      7:       return W_SIEB;
      default: return digit_word(d);
    endcase
  endfunction

  function automatic void say_group(int unsigned h, int unsigned t, int unsigned o,
                                    logic [CODE_W-1:0] lone_one);
    if (h != 0) begin
      phrase.push_back(ein_word(h));
      phrase.push_back(W_HUNDERT);
    end
    if (t == 1) begin
      case (o)
        0: phrase.push_back(W_ZEHN);
        1: phrase.push_back(W_ELF);
        2: phrase.push_back(W_ZWOELF);
        default: begin
          phrase.push_back(tens_stem(o));
          phrase.push_back(W_ZEHN);
        end
      endcase
    end else if (t > 1) begin
      if (o != 0) begin
        phrase.push_back(ein_word(o));
        phrase.push_back(W_UND);
      end
      phrase.push_back(tens_stem(t));
      phrase.push_back(W_ZIG);
    end else if (o == 1) begin
      phrase.push_back(lone_one);
    end else if (o != 0) begin
      phrase.push_back(digit_word(o));
    end
  endfunction

  function automatic void speak_number(logic [VALUE_W-1:0] value);
    int unsigned v;
    int unsigned dg[6];
    word_t       w;
    v = value;
    for (int i = 0; i < 6; i++) begin
      dg[i] = v % 10;
      v = v / 10;
    end
    phrase.delete();
    if (dg[5] != 0 || dg[4] != 0 || dg[3] != 0) begin
      say_group(dg[5], dg[4], dg[3], W_EIN);
      phrase.push_back(W_TAUSEND);
    end
    say_group(dg[2], dg[1], dg[0], W_ONE);
    if (phrase.size() == 0) phrase.push_back(W_NULL);
    foreach (phrase[i]) begin
      w.code = phrase[i];
      w.last = (i == phrase.size() - 1);
      expected_words.push_back(w);
    end
  endfunction

  // ---- stimulus ----
  task automatic set_idling(int gap_pct, int stall_pct);
    send_gap_pct   = gap_pct;
    sink_stall_pct = stall_pct;
  endtask

  // entered and left at a rising edge
  task automatic send_number(logic [VALUE_W-1:0] value);
    logic acc;
    if ($urandom_range(0, 99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_gap_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, value};
    do begin
      @(negedge clk);
      acc = s_tready;
      if (acc) speak_number(value);
      @(posedge clk);
    end while (!acc);
  endtask

  function automatic logic [VALUE_W-1:0] rand_value();
    int unsigned v;
    int unsigned r;
    v = 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 999999);
      4, 5: begin
        // digits biased to 0 and 1 to hit teens, silent zeros and ein
        for (int i = 0; i < 6; i++) begin
          r = $urandom_range(0, 3);
          v = v * 10 + ((r < 2) ? r : $urandom_range(0, 9));
        end
      end
      6: v = $urandom_range(0, 999);
      7: v = $urandom_range(1, 999) * 1000;
      8: v = $urandom_range(1000000, 1048575);
      default: v = $urandom & 32'h000F_FFFF;
    endcase
    return VALUE_W'(v);
  endfunction

  task automatic test_spoken_forms();
    int unsigned nums[$] = '{0, 1, 2, 10, 11, 12, 13, 16, 17, 20, 21, 67, 99, 100, 101,
                             111, 1000, 1001, 11000, 12000, 16000, 17017, 21021, 100000,
                             999999};
    foreach (nums[i]) send_number(VALUE_W'(nums[i]));
  endtask

  task automatic test_out_of_range_values();
    int unsigned nums[$] = '{1000000, 1000001, 1012345, 1048575};
    foreach (nums[i]) send_number(VALUE_W'(nums[i]));
    repeat (8) send_number(VALUE_W'($urandom_range(1000000, 1048575)));
  endtask

  task automatic test_random_numbers(int count);
    repeat (count) send_number(rand_value());
  endtask

  // ---- sink and word check ----
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(negedge clk) begin
    word_t exp_w;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_words.size() == 0) begin
        $error("word_code: expected none, actual %0d", m_tdata[CODE_W-1:0]);
        n_errors++;
      end else begin
        exp_w = expected_words.pop_front();
        if (m_tdata[CODE_W-1:0] !== exp_w.code) begin
          $error("word_code: expected %0d, actual %0d", exp_w.code, m_tdata[CODE_W-1:0]);
          n_errors++;
        end
        if (m_tlast !== exp_w.last) begin
          $error("last_word: expected %0d, actual %0d", exp_w.last, m_tlast);
          n_errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    set_idling(7, 58);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_spoken_forms();
    test_out_of_range_values();
    test_random_numbers(110);
    set_idling(58, 7);
    test_random_numbers(110);
    set_idling(0, 0);
    test_random_numbers(110);
    s_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
